/* sv/dns_query_message_builder_defines.svh */
// Assertion macros for the DNS query builder RTL.
`ifndef DNS_QUERY_MESSAGE_BUILDER_DEFINES_SVH
`define DNS_QUERY_MESSAGE_BUILDER_DEFINES_SVH

// Condition must never hold outside reset.
`define DQMB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DQMB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define DQMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/dqmb_pkg.sv */
// Types, constants and byte-selection helpers for the DNS query builder.
package dqmb_pkg;

  // Longest label kept; extra characters are dropped
  localparam int MAX_LABEL     = 32;
  localparam int CNT_W         = $clog2(MAX_LABEL + 1);
  localparam int IDX_W         = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

  // Message layout
  localparam int HDR_BYTES     = 12;
  localparam int HDR_RD_POS    = 2;
  localparam int QDCOUNT_INDEX = 5;
  localparam int TAIL_BYTES    = 5;
  localparam int STEP_W        = 4;
  localparam logic [STEP_W-1:0] HDR_LAST  = STEP_W'(HDR_BYTES - 1);
  localparam logic [STEP_W-1:0] TAIL_LAST = STEP_W'(TAIL_BYTES - 1);
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int QPTR_W     = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QCNT_W     = $clog2(CMDQ_DEPTH + 1);

  // Configuration register indexes
  localparam logic REG_QUERY_TYPE  = 1'b0;
  localparam logic REG_QUERY_CLASS = 1'b1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_CHAR  = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_CHAR,
    CMD_DOT,
    CMD_END
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] data;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmdq_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_LEN,
    ST_LBL,
    ST_TAIL
  } back_state_e;

  // Header byte at a given position: id, RD flag, QDCOUNT of one
  function automatic logic [7:0] hdr_byte(input logic [STEP_W-1:0] step,
                                          input logic [15:0] id);
    logic [7:0] b;
    b = 8'h00;
    if (step == STEP_W'(0))                  b = id[15:8];
    else if (step == STEP_W'(1))             b = id[7:0];
    else if (step == STEP_W'(HDR_RD_POS))    b = 8'h01;
    else if (step == STEP_W'(QDCOUNT_INDEX)) b = 8'h01;
    return b;
  endfunction

  // Trailer byte: root, QTYPE, QCLASS
  function automatic logic [7:0] tail_byte(input logic [STEP_W-1:0] step,
                                           input logic [15:0] qtype,
                                           input logic [15:0] qclass);
    logic [7:0] b;
    b = 8'h00;
    if (step == STEP_W'(1))      b = qtype[15:8];
    else if (step == STEP_W'(2)) b = qtype[7:0];
    else if (step == STEP_W'(3)) b = qclass[15:8];
    else if (step == STEP_W'(4)) b = qclass[7:0];
    return b;
  endfunction

endpackage

/* sv/dqmb_front.sv */
// Input front end: accepts transactions and classifies them into commands.
module dqmb_front import dqmb_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  name_char_i,
  input  logic [15:0] query_id_i,
  input  logic        q_full_i,
  output cmdq_wr_t    q_wr_o
);

  logic accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify; reserved operation is consumed without a command
  always_comb begin
    q_wr_o.push     = 1'b0;
    q_wr_o.cmd.kind = CMD_CHAR;
    q_wr_o.cmd.data = {8'h00, name_char_i};
    unique case (op_e'(operation_i))
      OP_START: begin
        q_wr_o.push     = accept;
        q_wr_o.cmd.kind = CMD_START;
        q_wr_o.cmd.data = query_id_i;
      end
      OP_CHAR: begin
        q_wr_o.push     = accept;
        q_wr_o.cmd.kind = (name_char_i == DOT_CHAR) ? CMD_DOT : CMD_CHAR;
      end
      OP_END: begin
        q_wr_o.push     = accept;
        q_wr_o.cmd.kind = CMD_END;
      end
      OP_NONE: begin
        q_wr_o.push = 1'b0;
      end
      default: begin
        q_wr_o.push = 1'b0;
      end
    endcase
  end

endmodule

/* sv/dqmb_cmdq.sv */
// Short command queue decoupling the front end from the byte sequencer.
module dqmb_cmdq import dqmb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cmdq_wr_t wr_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     empty_o,
  output cmd_t     head_o
);

  cmd_t              entry_q [CMDQ_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = wr_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wr_i.cmd;
    end
  end

endmodule

/* sv/dqmb_back.sv */
// Byte sequencer: label buffer, header, label flush and trailer output.
`include "dns_query_message_builder_defines.svh"
module dqmb_back import dqmb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  input  logic [15:0] qtype_i,
  input  logic [15:0] qclass_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        overflow_o
);

  back_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic              end_q, end_d;
  logic [15:0]       id_q, id_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              last_q, last_d;
  logic              ovf_out_q, ovf_out_d;
  logic [7:0]        store_q [MAX_LABEL];
  logic              wr_en;
  logic              can_emit;
  logic              lbl_done;

  assign can_emit    = !out_valid_q || out_ready_i;
  assign lbl_done    = (CNT_W'(pos_q + 1'b1) == cnt_q);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;
  assign overflow_o  = ovf_out_q;

  // Next state and output register
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    end_d       = end_q;
    id_d        = id_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    ovf_out_d   = ovf_out_q;
    pop_o       = 1'b0;
    wr_en       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.kind)
            CMD_START: begin
              cnt_d   = '0;
              ovf_d   = 1'b0;
              id_d    = cmd_i.data;
              step_d  = '0;
              state_d = ST_HDR;
            end
            CMD_CHAR: begin
              if (cnt_q < CNT_W'(MAX_LABEL)) begin
                wr_en = 1'b1;
                cnt_d = cnt_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_DOT: begin
              end_d   = 1'b0;
              state_d = ST_LEN;
            end
            CMD_END: begin
              end_d   = 1'b1;
              step_d  = '0;
              state_d = (cnt_q != '0) ? ST_LEN : ST_TAIL;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_HDR: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_byte_d  = hdr_byte(step_q, id_q);
          last_d      = (step_q == HDR_LAST);
          ovf_out_d   = ovf_q;
          step_d      = step_q + 1'b1;
          if (step_q == HDR_LAST) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_LEN: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_byte_d  = 8'(cnt_q);
          last_d      = !end_q && (cnt_q == '0);
          ovf_out_d   = ovf_q;
          pos_d       = '0;
          if (cnt_q != '0) begin
            state_d = ST_LBL;
          end else begin
            state_d = end_q ? ST_TAIL : ST_IDLE;
          end
        end
      end
      ST_LBL: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_byte_d  = store_q[pos_q[IDX_W-1:0]];
          last_d      = !end_q && lbl_done;
          ovf_out_d   = ovf_q;
          pos_d       = pos_q + 1'b1;
          if (lbl_done) begin
            cnt_d   = '0;
            state_d = end_q ? ST_TAIL : ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_byte_d  = tail_byte(step_q, qtype_i, qclass_i);
          last_d      = (step_q == TAIL_LAST);
          ovf_out_d   = ovf_q;
          step_d      = step_q + 1'b1;
          if (step_q == TAIL_LAST) begin
            end_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
    ovf_out_q  <= ovf_out_d;
  end

  // Label buffer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[cnt_q[IDX_W-1:0]] <= cmd_i.data[7:0];
    end
  end

  `DQMB_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CNT_W'(MAX_LABEL), "label count overrun")
  `DQMB_ASSERT_IMPLIES(a_pos_in_label, clk_i, rst_ni, state_q == ST_LBL, pos_q < cnt_q, "label read past count")
  `DQMB_ASSERT_NEXT(a_start_clears, clk_i, rst_ni, pop_o && cmd_i.kind == CMD_START, !ovf_q && cnt_q == '0, "start did not clear label state")
  `DQMB_ASSERT_NEXT(a_tail_ends, clk_i, rst_ni, state_q == ST_TAIL && can_emit && step_q == TAIL_LAST, state_q == ST_IDLE && out_valid_q && last_q, "trailer did not finish message")

endmodule

/* sv/dns_query_message_builder.sv */
// Top level of the DNS query message builder: config registers and block wiring.
// Builds a wire-format DNS query one byte per output transaction. A start transaction
// yields the 12-byte header (id, RD set, QDCOUNT one); name characters are buffered
// with no output; a dot yields the label length and the buffered label; an end
// yields any pending label, the root byte, QTYPE and QCLASS. last marks the final
// byte emitted for each start, dot or end, overflow reports labels cut at 32 characters.
// Timing: inputs enter a 2-entry command queue at up to one per cycle while it is not
// full. The single byte sequencer takes the next command only once it is back in idle,
// after all bytes of the last one; it emits one byte per cycle through the output
// register while the output side does not stall.
module dns_query_message_builder import dqmb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  name_char_i,
  input  logic [15:0] query_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        overflow_o
);

  logic [15:0] qtype_q;
  logic [15:0] qclass_q;
  cmdq_wr_t    q_wr;
  cmd_t        q_head;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qtype_q  <= 16'd1;
      qclass_q <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_QUERY_TYPE:  qtype_q  <= cfg_data_i;
        REG_QUERY_CLASS: qclass_q <= cfg_data_i;
        default: begin
          qtype_q <= qtype_q;
        end
      endcase
    end
  end

  dqmb_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .name_char_i (name_char_i),
    .query_id_i  (query_id_i),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr)
  );

  dqmb_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  dqmb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .cmd_i       (q_head),
    .pop_o       (q_pop),
    .qtype_i     (qtype_q),
    .qclass_i    (qclass_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .overflow_o  (overflow_o)
  );

endmodule
